@@ design/fafe_pkg.sv @@
// ----------------------------------------------------------------------------
// fafe_pkg: frame allocator fit engine shared definitions
// Store geometry, operation and status codes, datapath command types.
// ----------------------------------------------------------------------------
package fafe_pkg;

	localparam int FRAMES = 256;
	localparam int IDX_W  = $clog2(FRAMES);
	localparam int CNT_W  = IDX_W + 1;

	localparam logic [2:0] OP_CONTIG    = 3'd0;
	localparam logic [2:0] OP_SCATTER   = 3'd1;
	localparam logic [2:0] OP_REMOVE    = 3'd2;
	localparam logic [2:0] OP_FIND      = 3'd3;
	localparam logic [2:0] OP_COMPACT   = 3'd4;
	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ERR    = 2'd1;
	localparam logic [1:0] ST_NOHOLE = 2'd2;

	localparam logic [1:0] FIT_NEXT      = 2'd0;
	localparam logic [1:0] FIT_BEST      = 2'd1;
	localparam logic [1:0] FIT_WORST     = 2'd2;
	localparam logic [1:0] FIT_WORST_ALT = 2'd3;

	localparam logic [3:0] ACT_NONE   = 4'd0;
	localparam logic [3:0] ACT_CONTIG = 4'd1;
	localparam logic [3:0] ACT_SCAT   = 4'd2;
	localparam logic [3:0] ACT_RM_RD  = 4'd3;
	localparam logic [3:0] ACT_RM_EX  = 4'd4;
	localparam logic [3:0] ACT_NEXT1  = 4'd5;
	localparam logic [3:0] ACT_NEXT2  = 4'd6;
	localparam logic [3:0] ACT_BW     = 4'd7;
	localparam logic [3:0] ACT_CMP_RD = 4'd8;
	localparam logic [3:0] ACT_CMP_EX = 4'd9;

	typedef struct packed {
		logic       start;
		logic [3:0] act;
		logic       load_out;
	} cmd_t;

	typedef struct packed {
		logic stop;
		logic found;
		logic range_err;
		logic next_fit;
	} sts_t;

endpackage

@@ design/fafe_dp.sv @@
// ----------------------------------------------------------------------------
// fafe_dp: frame allocator datapath
// Occupancy flops, owner memory, scan counters, hole tracking, result regs.
// ----------------------------------------------------------------------------
module fafe_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  fafe_pkg::cmd_t      cmd,
	output fafe_pkg::sts_t      sts,
	input  logic [2:0]          op,
	input  logic [7:0]          owner_id,
	input  logic [7:0]          start_frame,
	input  logic [8:0]          frame_count,
	input  logic                fit_mode_we,
	input  logic [1:0]          fit_mode,
	output logic [1:0]          status,
	output logic [7:0]          hole_start,
	output logic [8:0]          tally
);
	import fafe_pkg::*;

	logic [FRAMES-1:0] occ_q;
	logic [FRAMES-1:0] occ_d;
	logic [7:0]        mem [FRAMES];
	logic [7:0]        rdata_q;

	logic [1:0]       fit_mode_q;
	logic [7:0]       id_q;
	logic [CNT_W-1:0] len_q;
	logic [CNT_W-1:0] end_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] w_q;
	logic [CNT_W-1:0] tally_q;
	logic [CNT_W-1:0] run_len_q;
	logic [IDX_W-1:0] run_start_q;
	logic [CNT_W-1:0] best_q;
	logic             found_q;
	logic [IDX_W-1:0] pos_q;
	logic [1:0]       status_q;
	logic [CNT_W-1:0] nfs_q;

	logic [IDX_W-1:0] idx;
	logic             at_end;
	logic             occ_i;
	logic [CNT_W:0]   sum_in;
	logic [CNT_W-1:0] run_nx;
	logic [IDX_W-1:0] rstart_nx;
	logic             fits_nx;
	logic             n2_origin;
	logic             cand;
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	logic [7:0]       mem_wd;

	assign idx       = i_q[IDX_W-1:0];
	assign at_end    = (i_q == CNT_W'(FRAMES));
	assign occ_i     = !at_end && occ_q[idx];
	assign sum_in    = {2'b00, start_frame} + {1'b0, frame_count};
	assign run_nx    = (run_len_q == '0) ? CNT_W'(1) : run_len_q + CNT_W'(1);
	assign rstart_nx = (run_len_q == '0) ? idx : run_start_q;
	assign fits_nx   = !occ_i && !at_end && (run_nx >= len_q);
	assign n2_origin = !occ_i && !at_end && (run_len_q == '0) && (i_q >= nfs_q);
	assign cand      = (run_len_q != '0) && (run_len_q >= len_q) &&
	                   (!found_q || ((fit_mode_q == FIT_BEST) ? (run_len_q < best_q)
	                                                         : (run_len_q > best_q)));

	always_comb begin
		sts.range_err = (sum_in > (CNT_W+1)'(FRAMES));
		sts.next_fit  = (fit_mode_q == FIT_NEXT);
		sts.stop      = 1'b0;
		sts.found     = 1'b0;
		case (cmd.act)
			ACT_CONTIG: sts.stop = (i_q == end_q) || occ_i;
			ACT_SCAT:   sts.stop = at_end || (tally_q == len_q);
			ACT_RM_RD:  sts.stop = at_end;
			ACT_CMP_RD: sts.stop = at_end;
			ACT_NEXT1: begin
				sts.found = fits_nx;
				sts.stop  = at_end || fits_nx;
			end
			ACT_NEXT2: begin
				sts.found = fits_nx && !n2_origin;
				sts.stop  = at_end || n2_origin || fits_nx;
			end
			ACT_BW:     sts.stop = at_end;
			default:    sts.stop = 1'b0;
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx;
		mem_wd = id_q;
		case (cmd.act)
			ACT_CONTIG: mem_we = !((i_q == end_q) || occ_i);
			ACT_SCAT:   mem_we = !(at_end || (tally_q == len_q)) && !occ_i;
			ACT_CMP_EX: begin
				mem_we = occ_i && (w_q != i_q);
				mem_wa = w_q[IDX_W-1:0];
				mem_wd = rdata_q;
			end
			default:    mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata_q <= mem[idx];
	end

	// next occupancy: set on placement, clear on removal, move on compaction
	always_comb begin
		occ_d = occ_q;
		case (cmd.act)
			ACT_CONTIG, ACT_SCAT: begin
				if (mem_we) begin
					occ_d[idx] = 1'b1;
				end
			end
			ACT_RM_EX: begin
				if (occ_i && rdata_q == id_q) begin
					occ_d[idx] = 1'b0;
				end
			end
			ACT_CMP_EX: begin
				if (mem_we) begin
					occ_d[w_q[IDX_W-1:0]] = 1'b1;
					occ_d[idx]            = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q      <= '0;
			nfs_q      <= '0;
			fit_mode_q <= FIT_NEXT;
		end else begin
			occ_q <= occ_d;
			if (fit_mode_we) begin
				fit_mode_q <= fit_mode;
			end
			if (cmd.act == ACT_CONTIG && i_q == end_q) begin
				nfs_q <= end_q;
			end
		end
	end

	// scan registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			id_q      <= owner_id;
			len_q     <= frame_count;
			end_q     <= sum_in[CNT_W-1:0];
			tally_q   <= '0;
			run_len_q <= '0;
			best_q    <= '0;
			found_q   <= 1'b0;
			pos_q     <= '0;
			w_q       <= '0;
			if (op == OP_CONTIG) begin
				i_q <= {1'b0, start_frame};
			end else if (op == OP_FIND && fit_mode_q == FIT_NEXT) begin
				i_q <= nfs_q;
			end else begin
				i_q <= '0;
			end
			if ((op == OP_CONTIG && sts.range_err) || op > OP_COMPACT) begin
				status_q <= ST_ERR;
			end else begin
				status_q <= ST_OK;
			end
		end else begin
			case (cmd.act)
				ACT_CONTIG: begin
					if (i_q != end_q) begin
						if (occ_i) begin
							status_q <= ST_ERR;
						end else begin
							tally_q <= tally_q + CNT_W'(1);
							i_q     <= i_q + CNT_W'(1);
						end
					end
				end
				ACT_SCAT: begin
					if (mem_we) begin
						tally_q <= tally_q + CNT_W'(1);
					end
					if (!at_end) begin
						i_q <= i_q + CNT_W'(1);
					end
				end
				ACT_RM_EX: begin
					if (occ_i && rdata_q == id_q) begin
						tally_q <= tally_q + CNT_W'(1);
					end
					i_q <= i_q + CNT_W'(1);
				end
				ACT_CMP_EX: begin
					if (occ_i) begin
						w_q <= w_q + CNT_W'(1);
					end
					if (mem_we) begin
						tally_q <= tally_q + CNT_W'(1);
					end
					i_q <= i_q + CNT_W'(1);
				end
				ACT_NEXT1, ACT_NEXT2: begin
					if (at_end || n2_origin && cmd.act == ACT_NEXT2) begin
						// phase over without a fit: rewind for the low-side pass; after that pass, report no hole
						i_q       <= '0;
						run_len_q <= '0;
						if (cmd.act == ACT_NEXT2) begin
							status_q <= ST_NOHOLE;
						end
					end else if (fits_nx) begin
						found_q <= 1'b1;
						pos_q   <= rstart_nx;
					end else begin
						run_len_q   <= occ_i ? '0 : run_nx;
						run_start_q <= rstart_nx;
						i_q         <= i_q + CNT_W'(1);
					end
				end
				ACT_BW: begin
					if (occ_i || at_end) begin
						if (cand) begin
							found_q <= 1'b1;
							best_q  <= run_len_q;
							pos_q   <= run_start_q;
						end
						run_len_q <= '0;
						if (at_end && !found_q && !cand) begin
							status_q <= ST_NOHOLE;
						end
					end else begin
						run_len_q   <= run_nx;
						run_start_q <= rstart_nx;
					end
					if (!at_end) begin
						i_q <= i_q + CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status     <= status_q;
			hole_start <= pos_q;
			tally      <= tally_q;
		end
	end

endmodule

@@ design/fafe_ctrl.sv @@
// ----------------------------------------------------------------------------
// fafe_ctrl: frame allocator controller
// Sequences the per-frame scan of each operation and owns the result valid.
// ----------------------------------------------------------------------------
module fafe_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [2:0]     op,
	output logic           out_valid,
	input  logic           out_stall,
	output fafe_pkg::cmd_t cmd,
	input  fafe_pkg::sts_t sts
);
	import fafe_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CONTIG = 4'd1;
	localparam logic [3:0] S_SCAT   = 4'd2;
	localparam logic [3:0] S_RM_RD  = 4'd3;
	localparam logic [3:0] S_RM_EX  = 4'd4;
	localparam logic [3:0] S_NEXT1  = 4'd5;
	localparam logic [3:0] S_NEXT2  = 4'd6;
	localparam logic [3:0] S_BW     = 4'd7;
	localparam logic [3:0] S_CMP_RD = 4'd8;
	localparam logic [3:0] S_CMP_EX = 4'd9;
	localparam logic [3:0] S_FINISH = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_nx;
	logic       out_free;

	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid || !out_stall;

	always_comb begin
		cmd.start    = 1'b0;
		cmd.act      = ACT_NONE;
		cmd.load_out = 1'b0;
		state_nx     = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					case (op)
						OP_CONTIG:  state_nx = sts.range_err ? S_FINISH : S_CONTIG;
						OP_SCATTER: state_nx = S_SCAT;
						OP_REMOVE:  state_nx = S_RM_RD;
						OP_FIND:    state_nx = sts.next_fit ? S_NEXT1 : S_BW;
						OP_COMPACT: state_nx = S_CMP_RD;
						default:    state_nx = S_FINISH;
					endcase
				end
			end
			S_CONTIG: begin
				cmd.act = ACT_CONTIG;
				if (sts.stop) state_nx = S_FINISH;
			end
			S_SCAT: begin
				cmd.act = ACT_SCAT;
				if (sts.stop) state_nx = S_FINISH;
			end
			S_RM_RD: begin
				cmd.act  = ACT_RM_RD;
				state_nx = sts.stop ? S_FINISH : S_RM_EX;
			end
			S_RM_EX: begin
				cmd.act  = ACT_RM_EX;
				state_nx = S_RM_RD;
			end
			S_NEXT1: begin
				cmd.act = ACT_NEXT1;
				if (sts.stop) state_nx = sts.found ? S_FINISH : S_NEXT2;
			end
			S_NEXT2: begin
				cmd.act = ACT_NEXT2;
				if (sts.stop) state_nx = S_FINISH;
			end
			S_BW: begin
				cmd.act = ACT_BW;
				if (sts.stop) state_nx = S_FINISH;
			end
			S_CMP_RD: begin
				cmd.act  = ACT_CMP_RD;
				state_nx = sts.stop ? S_FINISH : S_CMP_EX;
			end
			S_CMP_EX: begin
				cmd.act  = ACT_CMP_EX;
				state_nx = S_CMP_RD;
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load_out) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

@@ design/frame_allocator_fit_engine.sv @@
// ----------------------------------------------------------------------------
// frame_allocator_fit_engine: frame store with placement, removal, fit search
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// Contiguous place visits only its own frames; scattered place and best/worst
// fit scan the store at most once; next fit may take two scans; remove and
// compact read the owner memory of each frame before acting on it.
// One operation at a time; the next is taken once the result is
// in the output register. Reset clears occupancy flops, the next-fit origin
// and fit_mode at once; no clearing pass is needed.
module frame_allocator_fit_engine (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] op,
	input  logic [7:0] owner_id,
	input  logic [7:0] start_frame,
	input  logic [8:0] frame_count,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] status,
	output logic [7:0] hole_start,
	output logic [8:0] tally,
	input  logic       fit_mode_valid,
	output logic       fit_mode_ready,
	input  logic [1:0] fit_mode
);
	import fafe_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// fit_mode must only be rewritten while idle (the block does not enforce this), so always take the transfer
	assign fit_mode_ready = 1'b1;

	fafe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	fafe_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.op          (op),
		.owner_id    (owner_id),
		.start_frame (start_frame),
		.frame_count (frame_count),
		.fit_mode_we (fit_mode_valid && fit_mode_ready),
		.fit_mode    (fit_mode),
		.status      (status),
		.hole_start  (hole_start),
		.tally       (tally)
	);

	// an accepted operation holds off the next one while it runs
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again right after an accept");

	// a failed hole search reports no position and no frames
	a_nohole_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_NOHOLE) |-> (hole_start == 8'd0 && tally == 9'd0))
		else $error("no-hole result carries data");

	// errors never point at a hole
	a_err_no_hole: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_ERR) |-> (hole_start == 8'd0))
		else $error("error result carries a hole start");

endmodule

@@ verif/fafe_checker.sv @@
// ----------------------------------------------------------------------------
// fafe_checker: result predictor and comparator for the frame allocator
// Follows every input, result and fit-mode transfer, keeps its own frame
// store image, and compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module fafe_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [2:0] op,
	input  logic [7:0] owner_id,
	input  logic [7:0] start_frame,
	input  logic [8:0] frame_count,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [1:0] status,
	input  logic [7:0] hole_start,
	input  logic [8:0] tally,
	input  logic       fit_mode_valid,
	input  logic       fit_mode_ready,
	input  logic [1:0] fit_mode,
	output int         fail_count,
	output int         pending_count,
	output int         result_count
);
	import fafe_pkg::*;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] hole_start;
		logic [8:0] tally;
	} alloc_result_t;

	logic         occupied [FRAMES];
	logic [7:0]   owner_of [FRAMES];
	int           next_origin;
	logic [1:0]   policy;
	alloc_result_t expected_results [$];

	assign pending_count = expected_results.size();

	function automatic int free_run(int i);
		int n;
		n = 0;
		while (i < FRAMES && !occupied[i]) begin
			n++;
			i++;
		end
		return n;
	endfunction

	function automatic bit hole_begins(int i);
		return !occupied[i] && (i == 0 || occupied[i - 1]);
	endfunction

	function automatic bit search_hole(int req, output int pos);
		int  i, n, origin, cur;
		bit  found;
		pos = 0;
		found = 0;
		cur = 0;
		if (policy == FIT_NEXT) begin
			origin = next_origin > FRAMES ? FRAMES : next_origin;
			i = origin;
			while (i < FRAMES) begin
				if (!occupied[i]) begin
					n = free_run(i);
					if (n >= req) begin
						pos = i;
						return 1;
					end
					i += n;
				end else begin
					i++;
				end
			end
			for (i = 0; i < origin; i++)
				if (hole_begins(i) && free_run(i) >= req) begin
					pos = i;
					return 1;
				end
			return 0;
		end
		for (i = 0; i < FRAMES; i++) begin
			if (hole_begins(i)) begin
				n = free_run(i);
				if (n >= req && (!found || (policy == FIT_BEST ? n < cur : n > cur))) begin
					found = 1;
					cur = n;
					pos = i;
				end
			end
		end
		return found;
	endfunction

	function automatic alloc_result_t apply_operation(logic [2:0] code, logic [7:0] id,
			int off, int len);
		alloc_result_t r;
		int            i, w, pos, cnt;
		r = '0;
		cnt = 0;
		case (code)
			OP_CONTIG: begin
				if (off + len > FRAMES) begin
					r.status = ST_ERR;
				end else begin
					for (i = off; i < off + len; i++) begin
						if (occupied[i]) begin
							r.status = ST_ERR;
							break;
						end
						occupied[i] = 1;
						owner_of[i] = id;
						cnt++;
					end
					if (r.status == ST_OK)
						next_origin = off + len;
				end
			end
			OP_SCATTER: begin
				for (i = 0; i < FRAMES && cnt < len; i++)
					if (!occupied[i]) begin
						occupied[i] = 1;
						owner_of[i] = id;
						cnt++;
					end
			end
			OP_REMOVE: begin
				for (i = 0; i < FRAMES; i++)
					if (occupied[i] && owner_of[i] == id) begin
						occupied[i] = 0;
						owner_of[i] = '0;
						cnt++;
					end
			end
			OP_FIND: begin
				if (search_hole(len, pos))
					r.hole_start = pos[7:0];
				else
					r.status = ST_NOHOLE;
			end
			OP_COMPACT: begin
				w = 0;
				for (i = 0; i < FRAMES; i++)
					if (occupied[i]) begin
						if (w != i) begin
							occupied[w] = 1;
							owner_of[w] = owner_of[i];
							occupied[i] = 0;
							owner_of[i] = '0;
							cnt++;
						end
						w++;
					end
			end
			default: r.status = ST_ERR;
		endcase
		r.tally = cnt[8:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < FRAMES; i++) begin
				occupied[i] = 0;
				owner_of[i] = '0;
			end
			next_origin = 0;
			policy = FIT_NEXT;
			expected_results.delete();
			fail_count = 0;
			result_count = 0;
		end else begin
			if (fit_mode_valid && fit_mode_ready)
				policy = fit_mode;
			if (in_valid && !in_stall)
				expected_results.insert(expected_results.size(),
					apply_operation(op, owner_id, int'(start_frame), int'(frame_count)));
			if (out_valid && !out_stall) begin
				result_count++;
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: status %0d hole %0d tally %0d",
							status, hole_start, tally);
				end else begin
					want = expected_results.pop_front();
					if (want.status !== status || want.hole_start !== hole_start
							|| want.tally !== tally) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
								want.status, want.hole_start, want.tally,
								status, hole_start, tally);
					end
				end
			end
		end
	end

endmodule

@@ verif/tb_frame_allocator_fit_engine.sv @@
// ----------------------------------------------------------------------------
// tb_frame_allocator_fit_engine: stimulus and verdict for the allocator
// Drives directed and random operation mixes under each fit mode, with
// bursty input, random result stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_frame_allocator_fit_engine;
	import fafe_pkg::*;

	logic       clk = 0;
	logic       arst_n = 0;
	logic       in_valid = 0;
	logic       in_stall;
	logic [2:0] op = OP_CONTIG;
	logic [7:0] owner_id = '0;
	logic [7:0] start_frame = '0;
	logic [8:0] frame_count = '0;
	logic       out_valid;
	logic       out_stall = 0;
	logic [1:0] status;
	logic [7:0] hole_start;
	logic [8:0] tally;
	logic       fit_mode_valid = 0;
	logic       fit_mode_ready;
	logic [1:0] fit_mode = '0;
	int         fail_count, pending_count, result_count;
	bit         hold_off = 0;   // set by stimulus to ask for the long stall
	int         transfers_sent = 0;

	localparam int SETTLE_CYCLES = 600;

	always #4 clk = ~clk;

	frame_allocator_fit_engine u_dut (
		.clk, .arst_n, .in_valid, .in_stall, .op, .owner_id, .start_frame,
		.frame_count, .out_valid, .out_stall, .status, .hole_start, .tally,
		.fit_mode_valid, .fit_mode_ready, .fit_mode
	);

	fafe_checker u_checker (.*);

	// Receiver: random stall pattern, with calm stretches and one long hold.
	initial begin
		int mood;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_stall <= 1;
				repeat (3000) @(posedge clk);
				hold_off = 0;
				out_stall <= 0;
			end else begin
				mood = $urandom_range(0, 99);
				out_stall <= (mood < 30) && ((transfers_sent / 64) % 3 != 2);
			end
		end
	end

	// Wait for the result stream to drain, then for any trailing work.
	task automatic wait_idle();
		while (pending_count != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_fit_mode(logic [1:0] mode);
		fit_mode_valid <= 1;
		fit_mode <= mode;
		@(posedge clk);
		while (!fit_mode_ready)
			@(posedge clk);
		fit_mode_valid <= 0;
	endtask

	// Offer one operation and hold it until transferred.
	task automatic send_op(logic [2:0] code, logic [7:0] id, logic [7:0] off,
			logic [8:0] len);
		in_valid <= 1;
		op <= code;
		owner_id <= id;
		start_frame <= off;
		frame_count <= len;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		transfers_sent++;
	endtask

	task automatic idle_gap();
		in_valid <= 0;
		repeat ($urandom_range(1, 6)) @(posedge clk);
	endtask

	// Random operation: mostly placements and removes with small sizes.
	task automatic send_random();
		int         pick;
		logic [8:0] len;
		pick = $urandom_range(0, 99);
		len = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 256))
			: 9'($urandom_range(0, 24));
		if (pick < 30)
			send_op(OP_CONTIG, 8'($urandom_range(0, 7)) | (8'($urandom) & 8'hf8
				& {8{pick[0]}}), 8'($urandom), len);
		else if (pick < 45)
			send_op(OP_SCATTER, 8'($urandom_range(0, 7)), 8'($urandom), len);
		else if (pick < 60)
			send_op(OP_REMOVE, 8'($urandom_range(0, 7)), 8'($urandom), 9'($urandom));
		else if (pick < 88)
			send_op(OP_FIND, 8'($urandom), 8'($urandom), len);
		else if (pick < 95)
			send_op(OP_COMPACT, 8'($urandom), 8'($urandom), 9'($urandom));
		else
			send_op(3'($urandom_range(int'(OP_UNUSED_LO), int'(OP_UNUSED_HI))),
				8'($urandom), 8'($urandom), 9'($urandom));
	endtask

	initial begin
		logic [1:0] modes [5] = '{FIT_BEST, FIT_WORST, FIT_WORST_ALT, FIT_NEXT, FIT_BEST};
		int         burst;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: field extremes, each operation, error and empty cases.
		send_op(OP_FIND, 8'd0, 8'd0, 9'd256);
		send_op(OP_FIND, 8'd0, 8'd0, 9'd0);
		send_op(OP_CONTIG, 8'd255, 8'd255, 9'd2);      // runs past the end
		send_op(OP_CONTIG, 8'd1, 8'd10, 9'd0);         // zero length
		send_op(OP_CONTIG, 8'd1, 8'd10, 9'd20);
		send_op(OP_CONTIG, 8'd2, 8'd5, 9'd10);         // hits occupied frame
		send_op(OP_SCATTER, 8'd3, 8'd0, 9'd0);
		send_op(OP_SCATTER, 8'd3, 8'd0, 9'd7);
		send_op(OP_FIND, 8'd0, 8'd0, 9'd4);            // next fit inside a hole
		send_op(OP_FIND, 8'd0, 8'd0, 9'd300 & 9'h1ff);
		send_op(OP_CONTIG, 8'd255, 8'd200, 9'd56);     // reaches the last frame
		send_op(OP_FIND, 8'd0, 8'd0, 9'd3);            // wraps to low holes
		send_op(OP_REMOVE, 8'd1, 8'd0, 9'd0);
		send_op(OP_REMOVE, 8'd9, 8'd0, 9'd0);          // owner with no frames
		send_op(OP_COMPACT, 8'd0, 8'd0, 9'd0);
		send_op(OP_COMPACT, 8'd0, 8'd0, 9'd0);         // already packed
		send_op(OP_UNUSED_LO, 8'hff, 8'hff, 9'h1ff);
		send_op(OP_UNUSED_HI, 8'd0, 8'd0, 9'd0);
		send_op(OP_SCATTER, 8'd4, 8'd0, 9'd256);       // fills the store
		send_op(OP_FIND, 8'd0, 8'd0, 9'd1);            // full store, no hole
		send_op(OP_REMOVE, 8'd4, 8'd0, 9'd0);
		send_op(OP_REMOVE, 8'd255, 8'd0, 9'd0);
		send_op(OP_REMOVE, 8'd3, 8'd0, 9'd0);
		in_valid <= 0;

		// Random phases, one per entry of the mode list (best fit comes twice), with the long hold in the first.
		for (int phase = 0; phase < 5; phase++) begin
			wait_idle();
			write_fit_mode(modes[phase]);
			if (phase == 0)
				hold_off = 1;
			for (int n = 0; n < 100; ) begin
				burst = $urandom_range(1, 12);
				for (int k = 0; k < burst && n < 100; k++, n++)
					send_random();
				if ($urandom_range(0, 3) != 0)
					idle_gap();
			end
			in_valid <= 0;
		end

		wait_idle();
		$display("Ran %0d operations (%0d results) across every fit mode,",
			transfers_sent, result_count);
		$display("covering placement errors, wraparound search, full store and compaction.");
		if (fail_count == 0 && pending_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Safety stop far beyond the slowest correct run.
	initial begin
		#20000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
design/fafe_pkg.sv
design/fafe_dp.sv
design/fafe_ctrl.sv
design/frame_allocator_fit_engine.sv
verif/fafe_checker.sv
verif/tb_frame_allocator_fit_engine.sv
